### rtl/core/isc_pkg.sv
package isc_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 64;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT_DN,
    OP_SHIFT_UP
  } cell_op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     vld;
    logic                     gt;
  } nbr_t;

endpackage

### rtl/core/isc_cell.sv
module isc_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  isc_pkg::cell_op_t                op,
  input  logic signed [isc_pkg::DATA_W-1:0] new_val,
  input  logic                             lo_edge,
  input  isc_pkg::nbr_t                    lo,
  input  isc_pkg::nbr_t                    hi,
  output isc_pkg::nbr_t                    q
);

  logic signed [isc_pkg::DATA_W-1:0] val_r;
  logic signed [isc_pkg::DATA_W-1:0] val_nxt;
  logic                              vld_r;
  logic                              vld_nxt;
  logic                              gt;

  assign gt = vld_r && (val_r > new_val);
  assign q  = '{val: val_r, vld: vld_r, gt: gt};

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    unique case (op)
      isc_pkg::OP_HOLD: begin
      end
      isc_pkg::OP_INSERT: begin
        if (gt || (!vld_r && (lo_edge || lo.vld))) begin
          vld_nxt = 1'b1;
          val_nxt = (!lo_edge && lo.gt) ? lo.val : new_val;
        end
      end
      isc_pkg::OP_SHIFT_DN: begin
        val_nxt = hi.val;
        vld_nxt = hi.vld;
      end
      isc_pkg::OP_SHIFT_UP: begin
        val_nxt = lo.val;
        vld_nxt = lo_edge ? 1'b0 : lo.vld;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### rtl/core/integer_sort_engine.sv
// Batch sorter for signed 32-bit values. Values enter one per cycle and are
// placed in sorted position by a chain of MAX_ITEMS compare-and-shift cells.
// A request with in_last_item closes the batch; once it is taken the input
// stalls while the batch leaves on the out_ channel, one result per cycle
// while out_stall is low, with out_last_result on the final one. Results
// follow the closing request through the state register and the output
// register; in descending order the chain first shifts the batch to its
// top cell. Values beyond MAX_ITEMS are dropped. cfg_wr_data selects
// descending order and must only be written between batches.
module integer_sort_engine #(
  parameter int MAX_ITEMS = isc_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [isc_pkg::DATA_W-1:0] in_value,
  input  logic                              in_last_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [isc_pkg::DATA_W-1:0] out_sorted_value,
  output logic                              out_last_result
);

  isc_pkg::state_t   state_r;
  isc_pkg::state_t   state_nxt;
  isc_pkg::cell_op_t cell_op;
  isc_pkg::nbr_t     cell_q [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] vld_vec;

  logic                              order_r;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic signed [isc_pkg::DATA_W-1:0] out_value_r;
  logic signed [isc_pkg::DATA_W-1:0] out_value_nxt;
  logic                              out_last_r;
  logic                              out_last_nxt;
  logic                              out_free;
  logic                              in_acc;
  logic                              full;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
      isc_pkg::nbr_t lo_n;
      isc_pkg::nbr_t hi_n;
      if (gi == 0) begin : g_lo_edge
        assign lo_n = '0;
      end else begin : g_lo
        assign lo_n = cell_q[gi-1];
      end
      if (gi == MAX_ITEMS - 1) begin : g_hi_edge
        assign hi_n = '0;
      end else begin : g_hi
        assign hi_n = cell_q[gi+1];
      end
      isc_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (cell_op),
        .new_val (in_value),
        .lo_edge (gi == 0),
        .lo      (lo_n),
        .hi      (hi_n),
        .q       (cell_q[gi])
      );
      assign vld_vec[gi] = cell_q[gi].vld;
    end
  endgenerate

  assign full     = cell_q[MAX_ITEMS-1].vld;
  assign in_stall = (state_r != isc_pkg::ST_FILL);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cell_op       = isc_pkg::OP_HOLD;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      isc_pkg::ST_FILL: begin
        if (in_acc) begin
          if (!full) begin
            cell_op = isc_pkg::OP_INSERT;
          end
          if (in_last_item) begin
            state_nxt = isc_pkg::ST_DRAIN;
          end
        end
      end
      isc_pkg::ST_DRAIN: begin
        if (!order_r) begin
          if (out_free) begin
            cell_op       = isc_pkg::OP_SHIFT_DN;
            out_valid_nxt = 1'b1;
            out_value_nxt = cell_q[0].val;
            out_last_nxt  = !cell_q[1].vld;
          end
        end else if (!cell_q[MAX_ITEMS-1].vld) begin
          cell_op = isc_pkg::OP_SHIFT_UP;
        end else if (out_free) begin
          cell_op       = isc_pkg::OP_SHIFT_UP;
          out_valid_nxt = 1'b1;
          out_value_nxt = cell_q[MAX_ITEMS-1].val;
          out_last_nxt  = !cell_q[MAX_ITEMS-2].vld;
        end
        if (out_valid_nxt && out_free && out_last_nxt) begin
          state_nxt = isc_pkg::ST_FILL;
        end
      end
      default: begin
        state_nxt = isc_pkg::ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= isc_pkg::ST_FILL;
      order_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        order_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_result  = out_last_r;

`ifndef SYNTHESIS
  // outside of emission only the closing result may still wait
  a_fill_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == isc_pkg::ST_FILL && out_valid_r) |-> out_last_r)
    else $error("non-final result pending after batch emission");

  // while loading, occupied cells form a contiguous run from cell 0
  a_fill_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == isc_pkg::ST_FILL) |-> ((vld_vec & (vld_vec + 1'b1)) == '0))
    else $error("cell chain not packed during load");

  // emission starts only after a closing request
  a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == isc_pkg::ST_DRAIN) |-> $past(in_valid && !in_stall && in_last_item))
    else $error("emission without closing request");

  // the batch is never empty when emission begins
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == isc_pkg::ST_DRAIN) |-> (vld_vec != '0))
    else $error("empty batch at emission");
`endif

endmodule

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ITEMS   = isc_pkg::MAX_ITEMS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = MAX_ITEMS + 8;

  typedef struct packed {
    logic signed [isc_pkg::DATA_W-1:0] value;
    logic                              last_item;
  } sort_request_t;

  typedef struct packed {
    logic signed [isc_pkg::DATA_W-1:0] sorted_value;
    logic                              is_last;
  } sorted_result_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_wr_en = 1'b0;
  logic                              cfg_wr_data = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic signed [isc_pkg::DATA_W-1:0] in_value = '0;
  logic                              in_last_item = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [isc_pkg::DATA_W-1:0] out_sorted_value;
  logic                              out_last_result;

  sort_request_t                     pending_requests[$];
  sorted_result_t                    expected_results[$];
  logic signed [isc_pkg::DATA_W-1:0] held_sorted[MAX_ITEMS];
  int                                held_n = 0;
  bit                                sort_desc = 1'b0;
  int                                send_idle_pct = 0;
  int                                recv_idle_pct = 0;
  int                                mismatch_count = 0;
  int                                cycle_count = 0;

  integer_sort_engine #(.MAX_ITEMS(MAX_ITEMS)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_last_result  (out_last_result)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Held values are kept ascending; a closing request drains them in the
  // selected order. Values past MAX_ITEMS are dropped, even a closing one.
  function automatic void predict_sorted(input logic signed [isc_pkg::DATA_W-1:0] v,
                                         input logic last);
    sorted_result_t r;
    int j;
    int k;
    if (held_n < MAX_ITEMS) begin
      j = held_n;
      while (j > 0 && held_sorted[j-1] > v) begin
        held_sorted[j] = held_sorted[j-1];
        j--;
      end
      held_sorted[j] = v;
      held_n++;
    end
    if (last) begin
      for (k = 0; k < held_n; k++) begin
        r.sorted_value = sort_desc ? held_sorted[held_n-1-k] : held_sorted[k];
        r.is_last      = (k == held_n - 1);
        expected_results.push_back(r);
      end
      held_n = 0;
    end
  endfunction

  always @(posedge clk) begin
    sort_request_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_sorted(in_value, in_last_item);
      end
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req = pending_requests.pop_front();
        in_valid     <= 1'b1;
        in_value     <= req.value;
        in_last_item <= req.last_item;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    sorted_result_t exp_r;
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d last=%0b",
                                  out_sorted_value, out_last_result));
      end else begin
        exp_r = expected_results.pop_front();
        if (out_sorted_value !== exp_r.sorted_value) begin
          report_mismatch($sformatf("sorted_value got %0d exp %0d",
                                    out_sorted_value, exp_r.sorted_value));
        end
        if (out_last_result !== exp_r.is_last) begin
          report_mismatch($sformatf("last_result got %0b exp %0b (value %0d)",
                                    out_last_result, exp_r.is_last, exp_r.sorted_value));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_order(input bit desc);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= desc;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sort_desc = desc;
    @(negedge clk);
  endtask

  task automatic queue_request(input logic signed [isc_pkg::DATA_W-1:0] v, input logic last);
    sort_request_t r;
    r.value     = v;
    r.last_item = last;
    pending_requests.push_back(r);
  endtask

  function automatic logic signed [isc_pkg::DATA_W-1:0] pick_value();
    int s;
    case ($urandom_range(0, 3))
      0: begin
        s = $urandom_range(0, 8);
        pick_value = s - 4;
      end
      1: begin
        case ($urandom_range(0, 3))
          0: pick_value = 32'sh8000_0000;
          1: pick_value = 32'sh7fff_ffff;
          2: pick_value = '0;
          default: pick_value = -1;
        endcase
      end
      default: pick_value = $urandom;
    endcase
  endfunction

  task automatic queue_batch(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      queue_request(pick_value(), i == n - 1);
    end
  endtask

  initial begin
    int phase;
    int ord;
    int queued;
    int n;

    send_idle_pct = 14;
    recv_idle_pct = 48;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single-value batches at the extremes, duplicates, mixed signs
    set_order(1'b0);
    queue_request(32'sh7fff_ffff, 1'b1);
    queue_request(32'sh8000_0000, 1'b1);
    queue_request(5, 1'b0);
    queue_request(-3, 1'b0);
    queue_request(0, 1'b0);
    queue_request(-1, 1'b0);
    queue_request(32'sh7fff_ffff, 1'b0);
    queue_request(32'sh8000_0000, 1'b0);
    queue_request(1, 1'b0);
    queue_request(5, 1'b0);
    queue_request(5, 1'b1);

    set_order(1'b1);
    queue_request(3, 1'b0);
    queue_request(3, 1'b0);
    queue_request(-2, 1'b0);
    queue_request(32'sh7fff_ffff, 1'b0);
    queue_request(32'sh8000_0000, 1'b0);
    queue_request(0, 1'b1);
    queue_request(-1, 1'b1);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (ord = 0; ord < 2; ord++) begin
        set_order(ord[0]);
        queued = 0;
        // overflow: extra values and the closing value itself are dropped
        if (phase == 0 && ord == 0) begin
          queue_batch(MAX_ITEMS + 3);
          queued = MAX_ITEMS;
        end
        if (phase == 1 && ord == 1) begin
          queue_batch(MAX_ITEMS);
          queued = MAX_ITEMS;
        end
        while (queued < 12) begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
          queue_batch(n);
          queued += n;
        end
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/isc_pkg.sv
rtl/core/isc_cell.sv
rtl/core/integer_sort_engine.sv
tb/tb_top.sv
